// ===== hw/rtl/b32h_pkg.sv =====
// b32h_pkg: shared types and constants for the base32hex group decoder
// used by b32h_lane, b32h_merge and base32hex_group_decoder; no dependencies
`timescale 1ns / 1ps

package b32h_pkg;

    localparam int unsigned NUM_LANES  = 8;
    localparam int unsigned NUM_BYTES  = 5;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned VAL_W      = 5;
    localparam int unsigned COUNT_W    = 3;
    localparam int unsigned S_DATA_W   = NUM_LANES * CHAR_W;
    localparam int unsigned M_DATA_W   = 48;

    localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_LO = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_ALPHA_HI = 8'h56;
    localparam logic [CHAR_W-1:0] ALPHA_OFFSET  = 8'h37;
    localparam logic [CHAR_W-1:0] CHAR_PAD      = 8'h3D;

    // legal padding masks, bit i set when character i is padding
    localparam logic [NUM_LANES-1:0] PAD_NONE  = 8'b0000_0000;
    localparam logic [NUM_LANES-1:0] PAD_ONE   = 8'b1000_0000;
    localparam logic [NUM_LANES-1:0] PAD_THREE = 8'b1110_0000;
    localparam logic [NUM_LANES-1:0] PAD_FOUR  = 8'b1111_0000;
    localparam logic [NUM_LANES-1:0] PAD_SIX   = 8'b1111_1100;

    typedef struct packed {
        logic             is_data;
        logic             is_pad;
        logic [VAL_W-1:0] value;
    } t_lane_res;

    typedef struct packed {
        logic [NUM_BYTES*CHAR_W-1:0] bytes;
        logic [COUNT_W-1:0]          count;
        logic                        bad;
    } t_group_res;

endpackage

// ===== hw/rtl/b32h_lane.sv =====
// b32h_lane: classifies one character and produces its 5-bit value
// depends on b32h_pkg
`timescale 1ns / 1ps

module b32h_lane (
    input  logic [b32h_pkg::CHAR_W-1:0] i_char,
    output b32h_pkg::t_lane_res         o_res
);

    logic                        digit;
    logic                        alpha;
    logic [b32h_pkg::CHAR_W-1:0] diff;

    always_comb begin
        digit = (i_char >= b32h_pkg::CHAR_DIGIT_LO) && (i_char <= b32h_pkg::CHAR_DIGIT_HI);
        alpha = (i_char >= b32h_pkg::CHAR_ALPHA_LO) && (i_char <= b32h_pkg::CHAR_ALPHA_HI);
        if (digit) begin
            diff = i_char - b32h_pkg::CHAR_DIGIT_LO;
        end else if (alpha) begin
            diff = i_char - b32h_pkg::ALPHA_OFFSET;
        end else begin
            diff = '0;
        end
        o_res.is_data = digit || alpha;
        o_res.is_pad  = (i_char == b32h_pkg::CHAR_PAD);
        o_res.value   = diff[b32h_pkg::VAL_W-1:0];
    end

endmodule

// ===== hw/rtl/b32h_merge.sv =====
// b32h_merge: combines the eight lane results into bytes, count and error
// depends on b32h_pkg
`timescale 1ns / 1ps

module b32h_merge (
    input  b32h_pkg::t_lane_res [b32h_pkg::NUM_LANES-1:0] i_lanes,
    input  logic                                          i_last,
    output b32h_pkg::t_group_res                          o_res
);

    logic [b32h_pkg::NUM_LANES-1:0]              pad_mask;
    logic                                        bad_char;
    logic [b32h_pkg::NUM_LANES-1:0][4:0]         v;
    logic [b32h_pkg::NUM_BYTES-1:0][7:0]         b;
    logic [b32h_pkg::COUNT_W-1:0]                cnt;
    logic                                        bad;

    always_comb begin
        bad_char = 1'b0;
        for (int i = 0; i < b32h_pkg::NUM_LANES; i++) begin
            pad_mask[i] = i_lanes[i].is_pad && i_last;
            v[i]        = i_lanes[i].is_data ? i_lanes[i].value : 5'd0;
            if (!i_lanes[i].is_data && !pad_mask[i]) begin
                bad_char = 1'b1;
            end
        end

        b[0] = {v[0], v[1][4:2]};
        b[1] = {v[1][1:0], v[2], v[3][4]};
        b[2] = {v[3][3:0], v[4][4:1]};
        b[3] = {v[4][0], v[5], v[6][4:3]};
        b[4] = {v[6][2:0], v[7]};

        bad = bad_char;
        cnt = 3'd5;
        case (pad_mask)
            b32h_pkg::PAD_NONE: begin
                cnt = 3'd5;
            end
            b32h_pkg::PAD_ONE: begin
                cnt = 3'd4;
                if (v[6][2:0] != 3'd0) bad = 1'b1;
            end
            b32h_pkg::PAD_THREE: begin
                cnt = 3'd3;
                if (v[4][0] != 1'b0) bad = 1'b1;
            end
            b32h_pkg::PAD_FOUR: begin
                cnt = 3'd2;
                if (v[3][3:0] != 4'd0) bad = 1'b1;
            end
            b32h_pkg::PAD_SIX: begin
                cnt = 3'd1;
                if (v[1][1:0] != 2'd0) bad = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        o_res.bytes = b;
        o_res.count = cnt;
        o_res.bad   = bad;
    end

endmodule

// ===== hw/rtl/base32hex_group_decoder.sv =====
// base32hex_group_decoder: strict base32hex decoder, one 8-character group per transaction
// depends on b32h_pkg, b32h_lane, b32h_merge
`timescale 1ns / 1ps

// usage:
//   slave channel s_axis: tdata carries char0..char7 (char0 in bits 7:0),
//   tlast marks the last group of a string, where '=' padding is allowed.
//   master channel m_axis: tdata carries out_byte0..out_byte4 (byte0 in bits
//   7:0) and byte_count in bits 42:40; tuser is decode_error; tlast is
//   end_of_string. bytes at or beyond byte_count read as zero.
//   decode_error is sticky across the groups of one string and clears after
//   the result of the last group, so the consumer drops the whole string.
// result: registered in the output register and presented in the cycle after the transaction is accepted.
// throughput: one group per cycle unless m_axis_tready stalls; eight character lanes
//   and one merge stage feed a single output register, which refills in the cycle it drains.
// reset: i_rst_n low empties the output register and clears the sticky error.
// stall: while m_axis_tready is low a held result keeps s_axis_tready low;
//   the result stays stable until taken.
module base32hex_group_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [b32h_pkg::S_DATA_W-1:0]   s_axis_tdata,  // char0..char7
    input  logic                            s_axis_tlast,  // last_group
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [b32h_pkg::M_DATA_W-1:0]   m_axis_tdata,  // out_byte0..4, byte_count, zeros
    output logic                            m_axis_tuser,  // decode_error
    output logic                            m_axis_tlast   // end_of_string
);

    b32h_pkg::t_lane_res [b32h_pkg::NUM_LANES-1:0] lanes;
    b32h_pkg::t_group_res                          grp;

    logic                                   accept;
    logic                                   err;
    logic                                   r_valid;
    logic                                   n_valid;
    logic                                   r_error_seen;
    logic                                   n_error_seen;
    logic [b32h_pkg::NUM_BYTES*8-1:0]       r_bytes;
    logic [b32h_pkg::NUM_BYTES*8-1:0]       n_bytes;
    logic [b32h_pkg::COUNT_W-1:0]           r_count;
    logic [b32h_pkg::COUNT_W-1:0]           n_count;
    logic                                   r_err;
    logic                                   r_last;

    for (genvar g = 0; g < b32h_pkg::NUM_LANES; g++) begin : g_lane
        b32h_lane u_lane (
            .i_char (s_axis_tdata[g*b32h_pkg::CHAR_W +: b32h_pkg::CHAR_W]),
            .o_res  (lanes[g])
        );
    end

    b32h_merge u_merge (
        .i_lanes (lanes),
        .i_last  (s_axis_tlast),
        .o_res   (grp)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        err = grp.bad || r_error_seen;
        n_count = err ? '0 : grp.count;
        for (int i = 0; i < b32h_pkg::NUM_BYTES; i++) begin
            n_bytes[i*8 +: 8] = (i < int'(n_count)) ? grp.bytes[i*8 +: 8] : 8'd0;
        end
        n_valid      = accept ? 1'b1 : (r_valid && !m_axis_tready);
        n_error_seen = accept ? (!s_axis_tlast && err) : r_error_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_error_seen <= 1'b0;
        end else begin
            r_valid      <= n_valid;
            r_error_seen <= n_error_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bytes <= n_bytes;
            r_count <= n_count;
            r_err   <= err;
            r_last  <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(b32h_pkg::M_DATA_W - b32h_pkg::NUM_BYTES*8 - b32h_pkg::COUNT_W){1'b0}},
                            r_count, r_bytes};
    assign m_axis_tuser  = r_err;
    assign m_axis_tlast  = r_last;

    a_err_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (r_count == '0 && r_bytes == '0))
        else $error("error result carries data");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_count <= 3'd5))
        else $error("byte count out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tlast) |=> !r_error_seen)
        else $error("sticky error survived end of string");

    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> m_axis_tvalid)
        else $error("accepted group produced no result");

endmodule

// ===== tb/base32hex_group_decoder_test.sv =====
// base32hex_group_decoder_test: self-checking bench for the base32hex group decoder
// drives groups on s_axis, predicts each result and checks m_axis; depends on b32h_pkg
`timescale 1ns / 1ps

module base32hex_group_decoder_test;

    localparam int IDLE_PCT    = 12;
    localparam int RANDOM_GRPS = 850;
    localparam int QUIET_LIMIT = 1000;

    typedef struct packed {
        logic [b32h_pkg::NUM_BYTES*b32h_pkg::CHAR_W-1:0] bytes;
        logic [b32h_pkg::COUNT_W-1:0]                    count;
        logic                                            err;
        logic                                            eos;
    } t_group_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [b32h_pkg::S_DATA_W-1:0]   s_axis_tdata = '0;  // char0..char7
    logic                            s_axis_tlast = 1'b0;  // last_group
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [b32h_pkg::M_DATA_W-1:0]   m_axis_tdata;  // out_byte0..4, byte_count, zeros
    logic                            m_axis_tuser;  // decode_error
    logic                            m_axis_tlast;  // end_of_string

    t_group_result pending_results[$];
    logic          string_bad = 1'b0;
    bit            steady = 1'b0;
    int            groups_sent = 0;
    int            mismatches = 0;
    int            quiet_cycles = 0;

    base32hex_group_decoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_group_result decode_group(input logic [b32h_pkg::S_DATA_W-1:0] chars,
                                                   input logic is_last,
                                                   input logic earlier_bad);
        logic [b32h_pkg::VAL_W-1:0]                     val [b32h_pkg::NUM_LANES];
        logic [b32h_pkg::CHAR_W-1:0]                    c;
        logic [b32h_pkg::CHAR_W-1:0]                    d;
        logic [b32h_pkg::NUM_LANES*b32h_pkg::VAL_W-1:0] bits;
        int                                             pads;
        logic                                           bad;
        t_group_result                                  r;
        pads = 0;
        bad  = 1'b0;
        for (int i = 0; i < b32h_pkg::NUM_LANES; i++) begin
            c = chars[b32h_pkg::CHAR_W*i +: b32h_pkg::CHAR_W];
            val[i] = '0;
            if (c >= b32h_pkg::CHAR_DIGIT_LO && c <= b32h_pkg::CHAR_DIGIT_HI) begin
                if (pads != 0) bad = 1'b1;
                d = c - b32h_pkg::CHAR_DIGIT_LO;
                val[i] = d[b32h_pkg::VAL_W-1:0];
            end else if (c >= b32h_pkg::CHAR_ALPHA_LO && c <= b32h_pkg::CHAR_ALPHA_HI) begin
                if (pads != 0) bad = 1'b1;
                d = c - b32h_pkg::CHAR_ALPHA_LO + 8'd10;
                val[i] = d[b32h_pkg::VAL_W-1:0];
            end else if (c == b32h_pkg::CHAR_PAD && is_last) begin
                pads++;
            end else begin
                bad = 1'b1;
            end
        end
        r.count = 3'd5;
        if (!bad) begin
            case (pads)
                0: r.count = 3'd5;
                1: begin
                    r.count = 3'd4;
                    if (val[6][2:0] != 0) bad = 1'b1;
                end
                3: begin
                    r.count = 3'd3;
                    if (val[4][0] != 0) bad = 1'b1;
                end
                4: begin
                    r.count = 3'd2;
                    if (val[3][3:0] != 0) bad = 1'b1;
                end
                6: begin
                    r.count = 3'd1;
                    if (val[1][1:0] != 0) bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase
        end
        bits  = {val[0], val[1], val[2], val[3], val[4], val[5], val[6], val[7]};
        r.err = bad || earlier_bad;
        r.eos = is_last;
        if (r.err) r.count = '0;
        for (int k = 0; k < b32h_pkg::NUM_BYTES; k++) begin
            r.bytes[b32h_pkg::CHAR_W*k +: b32h_pkg::CHAR_W] =
                (k < r.count) ? bits[39-8*k -: 8] : 8'h00;
        end
        return r;
    endfunction

    function automatic logic [b32h_pkg::CHAR_W-1:0] to_char(input int v);
        int w;
        w = (v < 10) ? v : v - 10;
        return (v < 10) ? b32h_pkg::CHAR_DIGIT_LO + w[b32h_pkg::CHAR_W-1:0]
                        : b32h_pkg::CHAR_ALPHA_LO + w[b32h_pkg::CHAR_W-1:0];
    endfunction

    function automatic logic [b32h_pkg::S_DATA_W-1:0] text_group(input string s);
        logic [b32h_pkg::S_DATA_W-1:0] r;
        for (int i = 0; i < b32h_pkg::NUM_LANES; i++) r[b32h_pkg::CHAR_W*i +: b32h_pkg::CHAR_W] = s[i];
        return r;
    endfunction

    // random data characters followed by pads padding characters
    function automatic logic [b32h_pkg::S_DATA_W-1:0] make_group(input int pads, input bit clean);
        logic [b32h_pkg::S_DATA_W-1:0] r;
        int                            v;
        for (int i = 0; i < b32h_pkg::NUM_LANES; i++) begin
            if (i < b32h_pkg::NUM_LANES - pads) begin
                v = $urandom_range(0, 31);
                if (clean && i == b32h_pkg::NUM_LANES - 1 - pads) begin
                    case (pads)
                        1: v = v & ~32'h07;
                        3: v = v & ~32'h01;
                        4: v = v & ~32'h0F;
                        6: v = v & ~32'h03;
                        default: ;
                    endcase
                end
                r[b32h_pkg::CHAR_W*i +: b32h_pkg::CHAR_W] = to_char(v);
            end else begin
                r[b32h_pkg::CHAR_W*i +: b32h_pkg::CHAR_W] = b32h_pkg::CHAR_PAD;
            end
        end
        return r;
    endfunction

    task automatic send_group(input logic [b32h_pkg::S_DATA_W-1:0] chars, input logic is_last);
        t_group_result r;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= chars;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = decode_group(chars, is_last, string_bad);
        pending_results.push_back(r);
        string_bad = is_last ? 1'b0 : r.err;
        groups_sent++;
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_plain_groups();
        send_group(text_group("00000000"), 1'b0);
        send_group(text_group("VVVVVVVV"), 1'b1);
        send_group(text_group("01234567"), 1'b0);
        send_group(text_group("89ABCDEF"), 1'b0);
        send_group(text_group("GHIJKLMN"), 1'b0);
        send_group(text_group("OPQRSTUV"), 1'b1);
    endtask

    task automatic test_padding();
        // legal padding with clean trailing bits
        send_group(text_group("VVVVVVG="), 1'b1);
        send_group(text_group("VVVVU==="), 1'b1);
        send_group(text_group("VVVG===="), 1'b1);
        send_group(text_group("VS======"), 1'b1);
        // legal padding, nonzero unused bits
        send_group(text_group("VVVVVVV="), 1'b1);
        send_group(text_group("VVVVV==="), 1'b1);
        send_group(text_group("VVVV===="), 1'b1);
        send_group(text_group("VV======"), 1'b1);
        // illegal padding counts
        send_group(text_group("VVVVVV=="), 1'b1);
        send_group(text_group("VVV====="), 1'b1);
        send_group(text_group("V======="), 1'b1);
        send_group(text_group("========"), 1'b1);
        // padding in a middle group, then data after padding
        send_group(text_group("VVVVVVG="), 1'b0);
        send_group(text_group("00000000"), 1'b1);
        send_group(text_group("VV=V===="), 1'b1);
    endtask

    task automatic test_illegal_chars();
        send_group({8'h00, "@", ":", "/", "W", "a", 8'h80, 8'hFF}, 1'b0);
        send_group(text_group("00000000"), 1'b0);
        send_group(text_group("00000000"), 1'b1);
        send_group(text_group("00000000"), 1'b1);
    endtask

    task automatic test_random_strings();
        int                            n_groups;
        int                            pads;
        int                            pos;
        int                            rv;
        bit                            paused;
        logic                          is_last;
        logic [b32h_pkg::S_DATA_W-1:0] chars;
        int                            legal_pads [5] = '{0, 1, 3, 4, 6};
        int                            start;
        paused = 1'b0;
        start  = groups_sent;
        while (groups_sent - start < RANDOM_GRPS) begin
            steady = (groups_sent - start >= 300) && (groups_sent - start < 450);
            if (!paused && groups_sent - start >= 500) begin
                wait_for_drain();
                paused = 1'b1;
            end
            n_groups = $urandom_range(1, 5);
            for (int g = 0; g < n_groups; g++) begin
                is_last = (g == n_groups - 1);
                pads = 0;
                if (is_last && $urandom_range(0, 1)) begin
                    pads = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 8)
                                                        : legal_pads[$urandom_range(0, 4)];
                end
                chars = make_group(pads, $urandom_range(0, 99) >= 10);
                if ($urandom_range(0, 99) < 12) begin
                    pos = $urandom_range(0, b32h_pkg::NUM_LANES - 1);
                    rv  = $urandom_range(0, 255);
                    case ($urandom_range(0, 2))
                        0: chars[b32h_pkg::CHAR_W*pos +: b32h_pkg::CHAR_W] = rv[b32h_pkg::CHAR_W-1:0];
                        1: chars[b32h_pkg::CHAR_W*pos +: b32h_pkg::CHAR_W] = b32h_pkg::CHAR_PAD;
                        default: chars = {$urandom, $urandom};
                    endcase
                end
                send_group(chars, is_last);
            end
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_group_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no group pending");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < b32h_pkg::NUM_BYTES; k++) begin
                    if (m_axis_tdata[b32h_pkg::CHAR_W*k +: b32h_pkg::CHAR_W]
                        !== want.bytes[b32h_pkg::CHAR_W*k +: b32h_pkg::CHAR_W]) begin
                        $error("out_byte%0d: expected %h, got %h", k,
                               want.bytes[b32h_pkg::CHAR_W*k +: b32h_pkg::CHAR_W],
                               m_axis_tdata[b32h_pkg::CHAR_W*k +: b32h_pkg::CHAR_W]);
                        mismatches++;
                    end
                end
                if (m_axis_tdata[42:40] !== want.count) begin
                    $error("byte_count: expected %0d, got %0d", want.count, m_axis_tdata[42:40]);
                    mismatches++;
                end
                if (m_axis_tuser !== want.err) begin
                    $error("decode_error: expected %b, got %b", want.err, m_axis_tuser);
                    mismatches++;
                end
                if (m_axis_tlast !== want.eos) begin
                    $error("end_of_string: expected %b, got %b", want.eos, m_axis_tlast);
                    mismatches++;
                end
            end
        end
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_groups();
        test_padding();
        test_illegal_chars();
        test_random_strings();
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
